// File: rtl/assert_macros.svh
// shared assertion macros, clocked on clk_i and muted while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at an edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/clt_pkg.sv
`default_nettype none

package clt_pkg;

  localparam int unsigned LINE_BITS_DEF   = 24;
  localparam int unsigned COLUMN_BITS_DEF = 16;
  localparam int unsigned LENGTH_BITS_DEF = 12;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // token kinds as seen on the output
  typedef enum logic [3:0] {
    KIND_END    = 4'd0,
    KIND_IDENT  = 4'd1,
    KIND_LPAREN = 4'd2,
    KIND_RPAREN = 4'd3,
    KIND_LBRACE = 4'd4,
    KIND_RBRACE = 4'd5,
    KIND_COMMA  = 4'd6,
    KIND_SEMI   = 4'd7,
    KIND_STAR   = 4'd8,
    KIND_OTHER  = 4'd9
  } kind_e;

  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_DIG_0 && c <= CH_DIG_9) || (c == CH_USCORE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic kind_e punct_kind(input logic [7:0] c);
    kind_e k;
    case (c)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_COMMA:  k = KIND_COMMA;
      CH_SEMI:   k = KIND_SEMI;
      CH_STAR:   k = KIND_STAR;
      default:   k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: rtl/clt_if.sv
`default_nettype none

interface clt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       final_byte;

  modport source (output valid, output source_byte, output final_byte, input ready);
  modport sink (input valid, input source_byte, input final_byte, output ready);
endinterface

interface clt_token_if import clt_pkg::*; #(
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [3:0]             token_kind;
  logic [LENGTH_BITS-1:0] token_length;
  logic [LINE_BITS-1:0]   token_line;
  logic [COLUMN_BITS-1:0] token_column;
  logic [7:0]             first_char;
  logic                   run_end;

  modport source (output valid, output token_kind, output token_length, output token_line,
                  output token_column, output first_char, output run_end, input ready);
  modport sink (input valid, input token_kind, input token_length, input token_line,
                input token_column, input first_char, input run_end, output ready);
endinterface

`default_nettype wire

// File: rtl/c_like_tokenizer_core.sv
`default_nettype none

// Streaming lexer for C-like text: one source byte per beat in, tokens (identifier,
// seven punctuation kinds, other, end) out with length, start line, start column and
// first byte. A new byte is taken every cycle as long as the token queue between the
// lexing front end and the output stage has room (QUEUE_DEPTH bundles, each holding
// the one to three tokens one byte finishes). Bytes that finish no token never
// occupy the queue. The output stage sends one token per cycle from its output
// register while the sink is ready; the sustained rate is one byte per cycle while the
// text averages at most one token per byte and the sink stays ready. A byte's bundle is
// written into the queue at the edge that accepts the byte, and its first token is then
// loaded from the queue head into the output register, where it can be taken.
module c_like_tokenizer_core import clt_pkg::*; #(
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  clt_byte_if.sink    byte_i,
  clt_token_if.source token_o
);

  localparam int unsigned TOK_W   = 4 + LENGTH_BITS + LINE_BITS + COLUMN_BITS + 8;
  localparam int unsigned ENTRY_W = 2 + 3 * TOK_W;

  logic               q_push;
  logic [ENTRY_W-1:0] q_data;
  logic               q_ready;
  logic               head_valid;
  logic [ENTRY_W-1:0] head_data;
  logic               pop;

  clt_front #(
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_i),
    .q_ready_i(q_ready),
    .q_push_o (q_push),
    .q_data_o (q_data)
  );

  clt_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_data),
    .push_ready_o(q_ready),
    .head_valid_o(head_valid),
    .head_data_o (head_data),
    .pop_i       (pop)
  );

  clt_back #(
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_data_i (head_data),
    .pop_o       (pop),
    .token_o     (token_o)
  );

endmodule

`default_nettype wire

// File: rtl/clt_fifo.sv
`default_nettype none

`include "assert_macros.svh"

module clt_fifo import clt_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  push_ready_o,
  output logic                  head_valid_o,
  output logic      [WIDTH-1:0] head_data_o,
  input  wire logic             pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(DEPTH);

  logic [WIDTH-1:0] regs_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             full;

  assign full         = (cnt_q == CntFull);
  assign push_ready_o = !full;
  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = regs_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      regs_q[wr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full, "bundle pushed into full queue")
  `ASSERT_NEVER(a_no_underflow, pop_i && (cnt_q == '0), "pop from empty queue")
  `ASSERT_CLK(a_count_up, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)),
              "queue count lost a push")

endmodule

`default_nettype wire

// File: rtl/clt_front.sv
`default_nettype none

`include "assert_macros.svh"

module clt_front import clt_pkg::*; #(
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int unsigned TOK_W      = 4 + LENGTH_BITS + LINE_BITS + COLUMN_BITS + 8,
  localparam int unsigned ENTRY_W    = 2 + 3 * TOK_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  clt_byte_if.sink                byte_i,
  input  wire logic               q_ready_i,
  output logic                    q_push_o,
  output logic      [ENTRY_W-1:0] q_data_o
);

  typedef enum logic [5:0] {
    M_NORMAL = 6'b000001,
    M_IDENT  = 6'b000010,
    M_SLASH  = 6'b000100,
    M_LINE   = 6'b001000,
    M_BLOCK  = 6'b010000,
    M_BSTAR  = 6'b100000
  } mode_e;

  typedef struct packed {
    kind_e                  kind;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [7:0]             first;
  } tok_t;

  localparam logic [LINE_BITS-1:0]   LineOne = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] ColOne  = COLUMN_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LenOne  = LENGTH_BITS'(1);

  function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] x);
    return (x == '1) ? x : x + ColOne;
  endfunction

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] x);
    return (x == '1) ? x : x + LineOne;
  endfunction

  function automatic tok_t mk_tok(input kind_e k, input logic [LENGTH_BITS-1:0] n,
                                  input logic [LINE_BITS-1:0] ln,
                                  input logic [COLUMN_BITS-1:0] cl, input logic [7:0] f);
    tok_t t;
    t.kind  = k;
    t.len   = n;
    t.line  = ln;
    t.col   = cl;
    t.first = f;
    return t;
  endfunction

  mode_e                  mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d, sline_q, sline_d;
  logic [COLUMN_BITS-1:0] col_q, col_d, scol_q, scol_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [7:0]             first_q, first_d;
  logic [1:0]             cnt;
  tok_t                   slot [3];
  logic                   plain;
  logic                   accept;
  logic [7:0]             c;
  logic                   fin;

  assign byte_i.ready = q_ready_i;
  assign accept       = byte_i.valid && q_ready_i;
  assign c            = byte_i.source_byte;
  assign fin          = byte_i.final_byte;

  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    len_d   = len_q;
    first_d = first_q;
    cnt     = 2'd0;
    slot[0] = '0;
    slot[1] = '0;
    slot[2] = '0;
    plain   = 1'b0;

    case (mode_q)
      M_IDENT: begin
        if (is_ident(c)) begin
          len_d = (len_d == '1) ? len_d : len_d + LenOne;
          col_d = col_inc(col_d);
          if (fin) begin
            slot[cnt] = mk_tok(KIND_IDENT, len_d, sline_d, scol_d, first_d);
            cnt       = cnt + 2'd1;
            mode_d    = M_NORMAL;
          end
        end else begin
          slot[cnt] = mk_tok(KIND_IDENT, len_d, sline_d, scol_d, first_d);
          cnt       = cnt + 2'd1;
          mode_d    = M_NORMAL;
          plain     = 1'b1;
        end
      end
      M_SLASH: begin
        if (c == CH_SLASH) begin
          mode_d = M_LINE;
        end else if (c == CH_STAR) begin
          mode_d = M_BLOCK;
        end else begin
          // lone slash turns into an other token, then the byte lexes fresh
          slot[cnt] = mk_tok(KIND_OTHER, LenOne, sline_d, scol_d, CH_SLASH);
          cnt       = cnt + 2'd1;
          col_d     = col_inc(col_d);
          plain     = 1'b1;
        end
      end
      M_LINE: begin
        if (c == CH_NL) begin
          line_d = line_inc(line_d);
          col_d  = ColOne;
          mode_d = M_NORMAL;
        end
      end
      M_BLOCK: begin
        if (fin) begin
          plain = 1'b1;
        end else if (c == CH_STAR) begin
          mode_d = M_BSTAR;
        end else if (c == CH_NL) begin
          line_d = line_inc(line_d);
          col_d  = ColOne;
        end else begin
          col_d = col_inc(col_d);
        end
      end
      M_BSTAR: begin
        if (c == CH_SLASH) begin
          mode_d = M_NORMAL;
        end else begin
          // the pending star counts one column
          col_d = col_inc(col_d);
          if (fin) begin
            plain = 1'b1;
          end else if (c == CH_STAR) begin
            mode_d = M_BSTAR;
          end else if (c == CH_NL) begin
            line_d = line_inc(line_d);
            col_d  = ColOne;
            mode_d = M_BLOCK;
          end else begin
            col_d  = col_inc(col_d);
            mode_d = M_BLOCK;
          end
        end
      end
      default: plain = 1'b1;
    endcase

    if (plain) begin
      mode_d = M_NORMAL;
      if (c == CH_NL) begin
        line_d = line_inc(line_d);
        col_d  = ColOne;
      end else if (is_space(c)) begin
        col_d = col_inc(col_d);
      end else if (c == CH_SLASH && !fin) begin
        mode_d  = M_SLASH;
        sline_d = line_d;
        scol_d  = col_d;
      end else if (is_ident(c)) begin
        sline_d = line_d;
        scol_d  = col_d;
        len_d   = LenOne;
        first_d = c;
        col_d   = col_inc(col_d);
        mode_d  = M_IDENT;
        if (fin) begin
          slot[cnt] = mk_tok(KIND_IDENT, len_d, sline_d, scol_d, first_d);
          cnt       = cnt + 2'd1;
          mode_d    = M_NORMAL;
        end
      end else begin
        slot[cnt] = mk_tok(punct_kind(c), LenOne, line_d, col_d, c);
        cnt       = cnt + 2'd1;
        col_d     = col_inc(col_d);
      end
    end

    if (fin) begin
      slot[cnt] = mk_tok(KIND_END, '0, line_d, col_d, 8'h00);
      cnt       = cnt + 2'd1;
      mode_d    = M_NORMAL;
      line_d    = LineOne;
      col_d     = ColOne;
      sline_d   = LineOne;
      scol_d    = ColOne;
      len_d     = '0;
      first_d   = '0;
    end
  end

  // bytes that finish no token take no queue slot
  assign q_push_o = accept && (cnt != 2'd0);
  assign q_data_o = {cnt, slot[2], slot[1], slot[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_NORMAL;
      line_q  <= LineOne;
      col_q   <= ColOne;
      sline_q <= LineOne;
      scol_q  <= ColOne;
      len_q   <= '0;
      first_q <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      len_q   <= len_d;
      first_q <= first_d;
    end
  end

  `ASSERT_CLK(a_final_resets, (accept && fin) |=> (mode_q == M_NORMAL && line_q == LineOne),
              "state not back to start after final beat")
  `ASSERT_CLK(a_final_pushes, (accept && fin) |-> q_push_o, "final beat pushed no end token")

endmodule

`default_nettype wire

// File: rtl/clt_back.sv
`default_nettype none

`include "assert_macros.svh"

module clt_back import clt_pkg::*; #(
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int unsigned TOK_W      = 4 + LENGTH_BITS + LINE_BITS + COLUMN_BITS + 8,
  localparam int unsigned ENTRY_W    = 2 + 3 * TOK_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_valid_i,
  input  wire logic [ENTRY_W-1:0] head_data_i,
  output logic                    pop_o,
  clt_token_if.source             token_o
);

  typedef struct packed {
    kind_e                  kind;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [7:0]             first;
  } tok_t;

  logic [1:0] idx_q, idx_d;
  logic [1:0] head_cnt;
  logic       last;
  logic       load;
  logic       out_valid_q;
  tok_t       sel;
  tok_t       out_tok_q;
  logic       out_last_q;

  assign head_cnt = head_data_i[ENTRY_W-1 -: 2];
  assign last     = (idx_q == head_cnt - 2'd1);
  assign load     = head_valid_i && (!out_valid_q || token_o.ready);
  assign pop_o    = load && last;
  assign idx_d    = last ? 2'd0 : idx_q + 2'd1;

  always_comb begin
    case (idx_q)
      2'd1:    sel = tok_t'(head_data_i[TOK_W +: TOK_W]);
      2'd2:    sel = tok_t'(head_data_i[2*TOK_W +: TOK_W]);
      default: sel = tok_t'(head_data_i[0 +: TOK_W]);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      idx_q       <= idx_d;
      out_valid_q <= 1'b1;
    end else if (token_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_tok_q  <= sel;
      out_last_q <= last;
    end
  end

  assign token_o.valid        = out_valid_q;
  assign token_o.token_kind   = out_tok_q.kind;
  assign token_o.token_length = out_tok_q.len;
  assign token_o.token_line   = out_tok_q.line;
  assign token_o.token_column = out_tok_q.col;
  assign token_o.first_char   = out_tok_q.first;
  assign token_o.run_end      = out_last_q;

  `ASSERT_CLK(a_idx_in_bundle, head_valid_i |-> (idx_q < head_cnt), "slot index past bundle")
  `ASSERT_CLK(a_end_closes_run, (out_valid_q && out_tok_q.kind == KIND_END) |-> out_last_q,
              "end token not last of its beat")

endmodule

`default_nettype wire

// File: verif/tb_c_like_tokenizer_core.sv
`timescale 1ns / 1ps

module tb_c_like_tokenizer_core;
  import clt_pkg::*;

  localparam int LINE_W = LINE_BITS_DEF;
  localparam int COL_W  = COLUMN_BITS_DEF;
  localparam int LEN_W  = LENGTH_BITS_DEF;

  typedef enum logic [2:0] {
    SCAN_NORMAL,
    SCAN_WORD,
    SCAN_SLASH,
    SCAN_LINE_CMT,
    SCAN_BLOCK_CMT,
    SCAN_BLOCK_STAR
  } scan_e;

  typedef struct packed {
    kind_e             kind;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] ln;
    logic [COL_W-1:0]  col;
    logic [7:0]        first;
    logic              last;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    token_t     tok;
  } row_t;

  localparam token_t NO_TOK = '{KIND_END, 12'd0, 24'd0, 16'd0, 8'h00, 1'b0};

  localparam logic [7:0] PUNCT [7] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                       CH_COMMA, CH_SEMI, CH_STAR};
  localparam logic [7:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};

  localparam row_t DIRECTED [37] = '{
    '{CH_LPAREN, 1'b0, 1'b1, '{KIND_LPAREN, 12'd1, 24'd1, 16'd1, CH_LPAREN, 1'b1}},
    '{CH_LOW_A,  1'b0, 1'b0, NO_TOK},
    '{CH_DIG_9,  1'b0, 1'b0, NO_TOK},
    '{CH_RPAREN, 1'b0, 1'b0, NO_TOK},
    '{CH_NL,     1'b0, 1'b0, NO_TOK},
    // line comment swallowing a high byte
    '{CH_SLASH,  1'b0, 1'b0, NO_TOK},
    '{CH_SLASH,  1'b0, 1'b0, NO_TOK},
    '{8'hff,     1'b0, 1'b0, NO_TOK},
    '{CH_NL,     1'b0, 1'b0, NO_TOK},
    // block comment with a star before a newline, then a proper close
    '{CH_SLASH,  1'b0, 1'b0, NO_TOK},
    '{CH_STAR,   1'b0, 1'b0, NO_TOK},
    '{CH_STAR,   1'b0, 1'b0, NO_TOK},
    '{CH_NL,     1'b0, 1'b0, NO_TOK},
    '{CH_STAR,   1'b0, 1'b0, NO_TOK},
    '{CH_SLASH,  1'b0, 1'b0, NO_TOK},
    // slash that opens nothing
    '{CH_SLASH,  1'b0, 1'b0, NO_TOK},
    '{CH_COMMA,  1'b0, 1'b0, NO_TOK},
    '{8'h80,     1'b0, 1'b0, NO_TOK},
    '{CH_LBRACE, 1'b0, 1'b0, NO_TOK},
    '{CH_RBRACE, 1'b0, 1'b0, NO_TOK},
    '{CH_SEMI,   1'b0, 1'b0, NO_TOK},
    '{CH_STAR,   1'b0, 1'b0, NO_TOK},
    '{CH_USCORE, 1'b0, 1'b0, NO_TOK},
    '{8'h00,     1'b1, 1'b0, NO_TOK},
    '{CH_TAB,    1'b1, 1'b1, '{KIND_END, 12'd0, 24'd1, 16'd2, 8'h00, 1'b1}},
    // slash as the last byte
    '{CH_SLASH,  1'b1, 1'b0, NO_TOK},
    // three tokens from one beat
    '{CH_UP_Z,   1'b0, 1'b0, NO_TOK},
    '{CH_SLASH,  1'b0, 1'b0, NO_TOK},
    '{CH_RPAREN, 1'b1, 1'b0, NO_TOK},
    // open comment, star pending, ends on a plain byte
    '{CH_SLASH,  1'b0, 1'b0, NO_TOK},
    '{CH_STAR,   1'b0, 1'b0, NO_TOK},
    '{CH_STAR,   1'b0, 1'b0, NO_TOK},
    '{"q",       1'b1, 1'b0, NO_TOK},
    // open comment, star pending, last byte closes it
    '{CH_SLASH,  1'b0, 1'b0, NO_TOK},
    '{CH_STAR,   1'b0, 1'b0, NO_TOK},
    '{CH_STAR,   1'b0, 1'b0, NO_TOK},
    '{CH_SLASH,  1'b1, 1'b0, NO_TOK}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic sink_ready = 1'b0;

  int send_gap_pct = 31;
  int recv_gap_pct = 80;
  int err_cnt = 0;
  int live_cnt = 0;

  token_t tokens_due[$];
  token_t fresh_toks[$];

  // lexer state mirror
  scan_e             sc_mode;
  logic [LINE_W-1:0] cur_line;
  logic [COL_W-1:0]  cur_col;
  logic [LINE_W-1:0] tok_line;
  logic [COL_W-1:0]  tok_col;
  logic [LEN_W-1:0]  word_len;
  logic [7:0]        word_first;

  clt_byte_if  byte_if ();
  clt_token_if tok_if ();

  assign tok_if.ready = sink_ready;

  c_like_tokenizer_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .token_o (tok_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit word_char(input logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_DIG_0 && c <= CH_DIG_9) || c == CH_USCORE;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT || c == CH_FF ||
           c == CH_CR;
  endfunction

  function automatic kind_e sym_kind(input logic [7:0] c);
    case (c)
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_LBRACE: return KIND_LBRACE;
      CH_RBRACE: return KIND_RBRACE;
      CH_COMMA:  return KIND_COMMA;
      CH_SEMI:   return KIND_SEMI;
      CH_STAR:   return KIND_STAR;
      default:   return KIND_OTHER;
    endcase
  endfunction

  function automatic void scan_reset();
    sc_mode    = SCAN_NORMAL;
    cur_line   = LINE_W'(1);
    cur_col    = COL_W'(1);
    tok_line   = LINE_W'(1);
    tok_col    = COL_W'(1);
    word_len   = '0;
    word_first = '0;
  endfunction

  function automatic void bump_col();
    if (cur_col != '1) cur_col++;
  endfunction

  function automatic void next_line();
    if (cur_line != '1) cur_line++;
    cur_col = COL_W'(1);
  endfunction

  function automatic void add_tok(input kind_e k, input logic [LEN_W-1:0] n,
                                  input logic [LINE_W-1:0] ln, input logic [COL_W-1:0] cl,
                                  input logic [7:0] f);
    if (fresh_toks.size() < 3) fresh_toks.push_back('{k, n, ln, cl, f, 1'b0});
  endfunction

  function automatic void flush_word();
    add_tok(KIND_IDENT, word_len, tok_line, tok_col, word_first);
    sc_mode = SCAN_NORMAL;
  endfunction

  function automatic void lex_plain(input logic [7:0] c, input logic fin);
    sc_mode = SCAN_NORMAL;
    if (c == CH_NL) begin
      next_line();
    end else if (blank_char(c)) begin
      bump_col();
    end else if (c == CH_SLASH && !fin) begin
      sc_mode  = SCAN_SLASH;
      tok_line = cur_line;
      tok_col  = cur_col;
    end else if (word_char(c)) begin
      tok_line   = cur_line;
      tok_col    = cur_col;
      word_len   = LEN_W'(1);
      word_first = c;
      bump_col();
      sc_mode = SCAN_WORD;
      if (fin) flush_word();
    end else begin
      add_tok(sym_kind(c), LEN_W'(1), cur_line, cur_col, c);
      bump_col();
    end
  endfunction

  // tokens that one byte completes land in fresh_toks
  function automatic void lex_byte(input logic [7:0] c, input logic fin);
    fresh_toks.delete();
    case (sc_mode)
      SCAN_WORD: begin
        if (word_char(c)) begin
          if (word_len != '1) word_len++;
          bump_col();
          if (fin) flush_word();
        end else begin
          flush_word();
          lex_plain(c, fin);
        end
      end
      SCAN_SLASH: begin
        if (c == CH_SLASH) begin
          sc_mode = SCAN_LINE_CMT;
        end else if (c == CH_STAR) begin
          sc_mode = SCAN_BLOCK_CMT;
        end else begin
          add_tok(KIND_OTHER, LEN_W'(1), tok_line, tok_col, CH_SLASH);
          bump_col();
          lex_plain(c, fin);
        end
      end
      SCAN_LINE_CMT: begin
        if (c == CH_NL) begin
          next_line();
          sc_mode = SCAN_NORMAL;
        end
      end
      SCAN_BLOCK_CMT: begin
        if (fin) lex_plain(c, 1'b1);
        else if (c == CH_STAR) sc_mode = SCAN_BLOCK_STAR;
        else if (c == CH_NL) next_line();
        else bump_col();
      end
      SCAN_BLOCK_STAR: begin
        if (c == CH_SLASH) begin
          sc_mode = SCAN_NORMAL;
        end else begin
          // the held star takes its column now
          bump_col();
          if (fin) begin
            lex_plain(c, 1'b1);
          end else if (c == CH_STAR) begin
            sc_mode = SCAN_BLOCK_STAR;
          end else if (c == CH_NL) begin
            next_line();
            sc_mode = SCAN_BLOCK_CMT;
          end else begin
            bump_col();
            sc_mode = SCAN_BLOCK_CMT;
          end
        end
      end
      default: lex_plain(c, fin);
    endcase
    if (fin) begin
      add_tok(KIND_END, '0, cur_line, cur_col, 8'h00);
      scan_reset();
    end
    if (fresh_toks.size() != 0) fresh_toks[fresh_toks.size()-1].last = 1'b1;
  endfunction

  function automatic logic [7:0] word_pick();
    int r;
    r = $urandom_range(62);
    if (r < 26) return CH_LOW_A + 8'(r);
    if (r < 52) return CH_UP_A + 8'(r - 26);
    if (r < 62) return CH_DIG_0 + 8'(r - 52);
    return CH_USCORE;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_gap_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid       <= 1'b1;
    byte_if.source_byte <= b;
    byte_if.final_byte  <= fin;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
  endtask

  task automatic feed(input logic [7:0] b, input int fin_pct);
    logic fin;
    fin = ($urandom_range(99) < fin_pct);
    put_byte(b, fin);
    live_cnt++;
    lex_byte(b, fin);
    foreach (fresh_toks[i]) tokens_due.push_back(fresh_toks[i]);
  endtask

  // mostly well-formed text pieces, some noise
  task automatic send_fragment();
    int pick;
    int n;
    int r;
    pick = $urandom_range(99);
    if (pick < 30) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      repeat (n) feed(word_pick(), 3);
    end else if (pick < 50) begin
      feed(PUNCT[$urandom_range(6)], 3);
    end else if (pick < 65) begin
      feed(BLANKS[$urandom_range(5)], 3);
    end else if (pick < 73) begin
      feed(CH_SLASH, 3);
      feed(CH_SLASH, 3);
      repeat ($urandom_range(6)) feed(8'($urandom_range(255)), 3);
      feed(CH_NL, 3);
    end else if (pick < 83) begin
      feed(CH_SLASH, 3);
      feed(CH_STAR, 3);
      repeat ($urandom_range(8)) begin
        r = $urandom_range(3);
        if (r == 0) feed(CH_STAR, 3);
        else if (r == 1) feed(CH_NL, 3);
        else feed(8'($urandom_range(255)), 3);
      end
      feed(CH_STAR, 3);
      feed(CH_SLASH, 3);
    end else if (pick < 90) begin
      feed(CH_SLASH, 3);
    end else begin
      feed(8'($urandom_range(255)), 3);
    end
  endtask

  always @(posedge clk_i) begin
    sink_ready <= rst_ni && ($urandom_range(99) >= recv_gap_pct);
  end

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && tok_if.valid && tok_if.ready) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: token expected none got kind %0d", $time, tok_if.token_kind);
        err_cnt++;
      end else begin
        want = tokens_due.pop_front();
        check_field("token_kind", 32'(want.kind), 32'(tok_if.token_kind));
        check_field("token_length", 32'(want.len), 32'(tok_if.token_length));
        check_field("token_line", 32'(want.ln), 32'(tok_if.token_line));
        check_field("token_column", 32'(want.col), 32'(tok_if.token_column));
        check_field("first_char", 32'(want.first), 32'(tok_if.first_char));
        check_field("run_end", 32'(want.last), 32'(tok_if.run_end));
      end
    end
  end

  initial begin
    scan_reset();
    byte_if.valid       = 1'b0;
    byte_if.source_byte = '0;
    byte_if.final_byte  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      put_byte(DIRECTED[i].ch, DIRECTED[i].fin);
      lex_byte(DIRECTED[i].ch, DIRECTED[i].fin);
      if (DIRECTED[i].typed) tokens_due.push_back(DIRECTED[i].tok);
      else foreach (fresh_toks[j]) tokens_due.push_back(fresh_toks[j]);
    end

    while (live_cnt < 78) send_fragment();
    send_gap_pct = 80;
    recv_gap_pct = 31;
    while (live_cnt < 156) send_fragment();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    while (live_cnt < 232) send_fragment();

    // close the text so any pending token comes out
    feed(CH_COMMA, 100);

    byte_if.valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
